// ===== rtl/core/line_rasterizer_core_defines.svh =====
// Assertion macros shared by the line rasterizer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRAST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Next-cycle implication, disabled during reset.
`define LRAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

// ===== rtl/core/lrast_pkg.sv =====
// Types and constants for the line rasterizer.
// No dependencies; imported by every rasterizer module.
package lrast_pkg;

    localparam int CoordW = 6;
    localparam int ColorW = 32;

    typedef struct packed {
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] end_x;
        logic [CoordW-1:0] end_y;
        logic [ColorW-1:0] pixel_color;
    } t_line_cmd;

    typedef struct packed {
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
        logic [ColorW-1:0] out_color;
        logic              last_pixel;
    } t_pixel;

    // Classified line: major axis increasing from m0 to m1.
    typedef struct packed {
        logic              steep;
        logic              minor_dec;
        logic [CoordW-1:0] m0;
        logic [CoordW-1:0] n0;
        logic [CoordW-1:0] m1;
        logic [CoordW-1:0] dm;
        logic [CoordW-1:0] dn;
        logic [ColorW-1:0] color;
    } t_line_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// ===== rtl/core/lrast_front.sv =====
// Front end: accepts line commands and classifies them into jobs.
// Depends on lrast_pkg; feeds lrast_queue.
module lrast_front #(
    parameter int COORD_BITS = 6
) (
    input  lrast_pkg::t_line_cmd     i_cmd,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  lrast_pkg::t_queue_status i_q_status,
    output logic                     o_push,
    output lrast_pkg::t_line_job     o_job
);
    import lrast_pkg::*;

    localparam int CB = COORD_BITS;

    logic [CB-1:0] ax, ay, bx, by;
    logic [CB-1:0] span_x, span_y;
    logic          steep;
    logic [CB-1:0] ma, na, mb, nb;
    logic [CB-1:0] m0, n0, m1, n1;
    logic          minor_up;

    always_comb begin
        ax = i_cmd.start_x[CB-1:0];
        ay = i_cmd.start_y[CB-1:0];
        bx = i_cmd.end_x[CB-1:0];
        by = i_cmd.end_y[CB-1:0];

        span_x = (ax > bx) ? (ax - bx) : (bx - ax);
        span_y = (ay > by) ? (ay - by) : (by - ay);
        steep  = span_x < span_y;

        ma = steep ? ay : ax;
        na = steep ? ax : ay;
        mb = steep ? by : bx;
        nb = steep ? bx : by;

        if (ma > mb) begin
            m0 = mb; n0 = nb; m1 = ma; n1 = na;
        end else begin
            m0 = ma; n0 = na; m1 = mb; n1 = nb;
        end

        minor_up = n1 > n0;

        o_job.steep     = steep;
        o_job.minor_dec = !minor_up;
        o_job.m0        = CoordW'(m0);
        o_job.n0        = CoordW'(n0);
        o_job.m1        = CoordW'(m1);
        o_job.dm        = CoordW'(m1 - m0);
        o_job.dn        = minor_up ? CoordW'(n1 - n0) : CoordW'(n0 - n1);
        o_job.color     = i_cmd.pixel_color;
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

endmodule

// ===== rtl/core/lrast_queue.sv =====
// Two-entry job queue between the front end and the stepping engine.
// Depends on lrast_pkg.
module lrast_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  lrast_pkg::t_line_job     i_job,
    input  logic                     i_pop,
    output lrast_pkg::t_line_job     o_job,
    output lrast_pkg::t_queue_status o_status
);
    import lrast_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    t_line_job       r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == CntW'(Depth);
    assign o_status.empty = r_count == '0;

endmodule

// ===== rtl/core/lrast_back.sv =====
// Stepping engine: walks one job along its major axis, one pixel per beat.
// Depends on lrast_pkg; pulls jobs from lrast_queue.
module lrast_back #(
    parameter int COORD_BITS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lrast_pkg::t_line_job     i_job,
    input  lrast_pkg::t_queue_status i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output lrast_pkg::t_pixel        o_pixel
);
    import lrast_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    t_back_state r_state, n_state;

    logic                 r_steep, n_steep;
    logic                 r_dec, n_dec;
    logic [CB-1:0]        r_m, n_m;
    logic [CB-1:0]        r_n, n_n;
    logic [CB-1:0]        r_m1, n_m1;
    logic [CB-1:0]        r_dm, n_dm;
    logic [CB-1:0]        r_dn, n_dn;
    logic [ColorW-1:0]    r_color, n_color;
    logic signed [EW-1:0] r_err, n_err;

    logic   r_out_valid, n_out_valid;
    t_pixel r_out, n_out;

    logic                 advance;
    logic                 emit;
    logic                 last;
    logic signed [EW-1:0] inc;
    logic signed [EW-1:0] dm_s;
    logic signed [EW-1:0] err_add;

    assign advance = !r_out_valid || !i_stall;
    assign last    = r_m == r_m1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (advance && last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_q_status.empty;
            BK_RUN:  emit  = advance;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_comb begin
        inc     = EW'({r_dn, 1'b0});
        dm_s    = EW'(r_dm);
        err_add = r_err + inc;

        n_steep = r_steep;
        n_dec   = r_dec;
        n_m     = r_m;
        n_n     = r_n;
        n_m1    = r_m1;
        n_dm    = r_dm;
        n_dn    = r_dn;
        n_color = r_color;
        n_err   = r_err;

        if (o_pop) begin
            n_steep = i_job.steep;
            n_dec   = i_job.minor_dec;
            n_m     = i_job.m0[CB-1:0];
            n_n     = i_job.n0[CB-1:0];
            n_m1    = i_job.m1[CB-1:0];
            n_dm    = i_job.dm[CB-1:0];
            n_dn    = i_job.dn[CB-1:0];
            n_color = i_job.color;
            n_err   = '0;
        end else if (emit) begin
            n_m = r_m + 1'b1;
            if (err_add > dm_s) begin
                n_n   = r_dec ? (r_n - 1'b1) : (r_n + 1'b1);
                n_err = err_add - (dm_s <<< 1);
            end else begin
                n_err = err_add;
            end
        end

        n_out = r_out;
        if (emit) begin
            n_out.pixel_x    = CoordW'(r_steep ? r_n : r_m);
            n_out.pixel_y    = CoordW'(r_steep ? r_m : r_n);
            n_out.out_color  = r_color;
            n_out.last_pixel = last;
        end
        n_out_valid = emit ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep <= n_steep;
        r_dec   <= n_dec;
        r_m     <= n_m;
        r_n     <= n_n;
        r_m1    <= n_m1;
        r_dm    <= n_dm;
        r_dn    <= n_dn;
        r_color <= n_color;
        r_err   <= n_err;
        r_out   <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

endmodule

// ===== rtl/core/line_rasterizer_core.sv =====
// Line rasterizer top level: integer line drawing over a square tile.
// Depends on lrast_pkg, lrast_front, lrast_queue, lrast_back and the defines header.
//
// Usage:
//   Command channel: i_cmd carries two endpoints and a color; a beat is taken
//   when i_valid is high and o_stall is low. o_stall rises only while the
//   two-entry job queue is full.
//   Pixel channel: o_pixel carries x, y, color and a last-pixel flag; a beat
//   leaves when o_valid is high and i_stall is low.
//   A line of L major-axis steps yields L+1 pixels (1 to 2^COORD_BITS).
//   A command is written into the job queue, popped into the stepping engine,
//   and each pixel is registered before it leaves. While a line runs and the
//   output is not stalled, one pixel leaves per cycle; the engine does one add
//   and compare per pixel and pops the next job only after a line's last pixel.
//   While i_stall is high with a pixel pending, the pixel register holds and the
//   stepping engine waits; commands keep flowing into the queue until it fills.
//   Reset (i_rst_n low, synchronous) empties the queue, idles the engine and
//   drops any pending pixel.
module line_rasterizer_core #(
    parameter int COORD_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lrast_pkg::t_line_cmd i_cmd,
    output logic                 o_valid,
    input  logic                 i_stall,
    output lrast_pkg::t_pixel    o_pixel
);
    import lrast_pkg::*;

    `include "line_rasterizer_core_defines.svh"

    logic          push;
    logic          pop;
    t_line_job     front_job;
    t_line_job     queue_job;
    t_queue_status q_status;

    lrast_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_cmd     (i_cmd),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_q_status(q_status),
        .o_push    (push),
        .o_job     (front_job)
    );

    lrast_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_status(q_status)
    );

    lrast_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (queue_job),
        .i_q_status(q_status),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pixel   (o_pixel)
    );

    `LRAST_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, push, !q_status.full)
    `LRAST_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, pop, !q_status.empty)
    `LRAST_ASSERT_NEXT(a_line_continues, i_clk, i_rst_n,
        o_valid && !i_stall && !o_pixel.last_pixel, o_valid)

endmodule
